FILE: sv/pvat_pkg.sv
// Shared constants and types for the packed vertex affine transform.
`timescale 1ns / 1ps
package pvat_pkg;

    localparam int COEF_W     = 20;
    localparam int TRANS_W    = 21;
    localparam int VTX_W      = 10;
    localparam int COORD_W    = 24;
    localparam int Q_FRAC     = 8;
    localparam int FRAC_SHIFT = 12;
    localparam int OUT_W      = 40;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int TVEC_W     = 3 * TRANS_W;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int SUM_W      = PROD_W + 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]   result_t;

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_TRANS = 2'd3
    } cfg_idx_t;

endpackage

FILE: sv/pvat_row.sv
// One output row: three products, sum with offset, truncate and saturate.
`timescale 1ns / 1ps
module pvat_row (
    input  logic                             clk,
    input  logic [pvat_pkg::ROW_W-1:0]       coeffs,
    input  logic signed [pvat_pkg::TRANS_W-1:0] toff,
    input  pvat_pkg::coord_t                 x,
    input  pvat_pkg::coord_t                 y,
    input  pvat_pkg::coord_t                 z,
    output pvat_pkg::result_t                result
);
    import pvat_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (OUT_W - 1));
    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = (SUM_W'(1) <<< FRAC_SHIFT) - SUM_W'(1);

    logic signed [PROD_W-1:0] op_c [3];
    logic signed [PROD_W-1:0] op_k [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  quot;
    result_t                  result_next;
    result_t                  result_reg;

    always_comb
    begin
        op_c[0] = PROD_W'(x);
        op_c[1] = PROD_W'(y);
        op_c[2] = PROD_W'(z);
        for (int j = 0; j < 3; j++)
        begin
            op_k[j]      = PROD_W'($signed(coeffs[j*COEF_W +: COEF_W]));
            prod_next[j] = op_c[j] * op_k[j];
        end
    end

    // Offset is an integer: scale it up to the product's Q.20 position.
    always_comb
    begin
        sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                 + (SUM_W'(toff) <<< (Q_FRAC + FRAC_SHIFT));
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift.
    always_comb
    begin
        quot = (sum_reg + (sum_reg[SUM_W-1] ? TRUNC_BIAS : SUM_W'(0))) >>> FRAC_SHIFT;
        if (quot > SAT_HI)
        begin
            result_next = SAT_HI[OUT_W-1:0];
        end
        else if (quot < SAT_LO)
        begin
            result_next = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            result_next = quot[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: sv/packed_vertex_affine_transform_top.sv
// Top level of the packed vertex affine transform with its register port.
//
// Usage: load the three coefficient rows and the translation through the
// APB port (64-bit data, registers at byte addresses 0, 8, 16, 24; pready is
// always high) while no vertex is in flight. Then issue one vertex request per
// cycle with start; busy is always low, so every start is taken. A request
// carries either a packed word of three 10-bit coordinates (kind 0) or three
// Q16.8 coordinates (kind 1), plus a batch-end mark.
// Each request yields one result: done pulses for one cycle with out_x, out_y,
// out_z (Q32.8, truncated toward zero, saturated) and batch_end_out.
// Throughput is one vertex per cycle through the pipeline of input register,
// nine 24x20 multipliers, a four-term adder and the truncate/saturate stage,
// one register level each.
// Reset clears the configuration registers and the pipeline valids; requests in
// flight are dropped. The receiver cannot stall: results are shown for exactly
// one cycle.
`timescale 1ns / 1ps
module packed_vertex_affine_transform_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvat_pkg::ADDR_W-1:0]   paddr,
    input  logic [pvat_pkg::DATA_W-1:0]   pwdata,
    output logic [pvat_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [3*pvat_pkg::VTX_W-1:0]  packed_vertex,
    input  pvat_pkg::coord_t              coord_x,
    input  pvat_pkg::coord_t              coord_y,
    input  pvat_pkg::coord_t              coord_z,
    input  logic                          batch_end,
    output logic                          done,
    output pvat_pkg::result_t             out_x,
    output pvat_pkg::result_t             out_y,
    output pvat_pkg::result_t             out_z,
    output logic                          batch_end_out
);
    import pvat_pkg::*;

    logic [ROW_W-1:0]  row_x_reg;
    logic [ROW_W-1:0]  row_y_reg;
    logic [ROW_W-1:0]  row_z_reg;
    logic [TVEC_W-1:0] trans_reg;
    logic              cfg_wr;
    cfg_idx_t          cfg_idx;

    coord_t            c_next [3];
    coord_t            c_reg [3];
    logic              accept;
    logic [3:0]        vld_reg;
    logic [3:0]        be_reg;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[ADDR_W-1:3]);
    assign accept  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            trans_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ROW_X: row_x_reg <= pwdata[ROW_W-1:0];
                REG_ROW_Y: row_y_reg <= pwdata[ROW_W-1:0];
                REG_ROW_Z: row_z_reg <= pwdata[ROW_W-1:0];
                REG_TRANS: trans_reg <= pwdata[TVEC_W-1:0];
                default:   trans_reg <= trans_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_X: prdata = DATA_W'(row_x_reg);
            REG_ROW_Y: prdata = DATA_W'(row_y_reg);
            REG_ROW_Z: prdata = DATA_W'(row_z_reg);
            REG_TRANS: prdata = DATA_W'(trans_reg);
            default:   prdata = '0;
        endcase
    end

    // Widen each packed coordinate to Q.8 at the input register; kind 1 coordinates pass as given.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            c_next[j] = COORD_W'($signed(packed_vertex[j*VTX_W +: VTX_W])) <<< Q_FRAC;
        end
        if (kind)
        begin
            c_next[0] = coord_x;
            c_next[1] = coord_y;
            c_next[2] = coord_z;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            be_reg  <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], accept};
            be_reg  <= {be_reg[2:0], batch_end};
        end
    end

    pvat_row u_row_x (
        .clk    (clk),
        .coeffs (row_x_reg),
        .toff   ($signed(trans_reg[0 +: TRANS_W])),
        .x      (c_reg[0]),
        .y      (c_reg[1]),
        .z      (c_reg[2]),
        .result (out_x)
    );

    pvat_row u_row_y (
        .clk    (clk),
        .coeffs (row_y_reg),
        .toff   ($signed(trans_reg[TRANS_W +: TRANS_W])),
        .x      (c_reg[0]),
        .y      (c_reg[1]),
        .z      (c_reg[2]),
        .result (out_y)
    );

    pvat_row u_row_z (
        .clk    (clk),
        .coeffs (row_z_reg),
        .toff   ($signed(trans_reg[2*TRANS_W +: TRANS_W])),
        .x      (c_reg[0]),
        .y      (c_reg[1]),
        .z      (c_reg[2]),
        .result (out_z)
    );

    assign done          = vld_reg[3];
    assign batch_end_out = be_reg[3];

    // A result appears for each accepted request, unless reset hit while it was in flight.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == ($past(start && !busy && rst_n, 4) && $past(rst_n, 3)
                 && $past(rst_n, 2) && $past(rst_n, 1)))
        else $error("done does not match request four cycles earlier");

    a_batch_mark: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (batch_end_out == $past(batch_end, 4)))
        else $error("batch_end_out does not follow its request");

endmodule
